/* rtl/pal_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list package
// Shared types and constants for the positional array list core.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int POS_W     = 5;
  localparam int COUNT_W   = 5;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  position;
    word_t             value_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    word_t              value_out;
    logic [POS_W-1:0]   found_position;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   k;
    word_t              value;
    logic [COUNT_W-1:0] count;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/positional_array_list_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list core
// Fixed-capacity ordered list of signed words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Every request is handled in a row of entry cells that shift and compare
// all at once; its result beat is shown on out_strobe in the cycle
// after start. Busy stays low, so a request can be issued on every cycle, and
// the receiver must take each result beat in the cycle that it appears.
// ----------------------------------------------------------------------------
module positional_array_list_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire pal_pkg::req_t  in_req,
  output logic                out_strobe,
  output pal_pkg::res_t       out_res
);
  import pal_pkg::*;

  cell_cmd_t               cmd;
  word_t [DEPTH-1:0]       cell_data;
  logic  [DEPTH-1:0]       cell_match;

  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .cell_data  (cell_data),
    .cell_match (cell_match),
    .cmd        (cmd),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (g == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    pal_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (IDX_W'(g)),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

endmodule
`default_nettype wire

/* rtl/pal_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list cell
// Holds one entry, shifts with its neighbors and compares against the key.
// ----------------------------------------------------------------------------
module pal_cell (
  input  wire logic                  clk,
  input  wire pal_pkg::cell_cmd_t    cmd,
  input  wire logic [pal_pkg::IDX_W-1:0] idx,
  input  wire pal_pkg::word_t        left_data,
  input  wire pal_pkg::word_t        right_data,
  output pal_pkg::word_t             data,
  output logic                       match
);
  import pal_pkg::*;

  word_t entry_r;
  word_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      OP_INSERT: begin
        if (idx == cmd.k) begin
          entry_nxt = cmd.value;
        end else if (idx > cmd.k) begin
          entry_nxt = left_data;
        end
      end
      OP_DELETE: begin
        if (idx >= cmd.k) begin
          entry_nxt = right_data;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data  = entry_r;
  assign match = (entry_r == cmd.value) &&
                 ({{(COUNT_W-IDX_W){1'b0}}, idx} < cmd.count);

endmodule
`default_nettype wire

/* rtl/pal_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list control
// Decodes requests, drives the cell row, keeps the fill count and registers
// the result beat.
// ----------------------------------------------------------------------------
module pal_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire pal_pkg::req_t         in_req,
  input  wire pal_pkg::word_t [pal_pkg::DEPTH-1:0] cell_data,
  input  wire logic [pal_pkg::DEPTH-1:0] cell_match,
  output pal_pkg::cell_cmd_t         cmd,
  output logic                       out_strobe,
  output pal_pkg::res_t              out_res
);
  import pal_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  res_t               out_r;
  res_t               res_nxt;
  logic               accept;
  logic [COUNT_W:0]   pos_ext;
  logic [COUNT_W:0]   cnt_ext;
  logic [IDX_W-1:0]   k_idx;
  logic               ins_ok;
  logic               rd_ok;
  logic               found;
  logic [POS_W-1:0]   found_pos;
  cell_op_t           op;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = {1'b0, in_req.position};
  assign cnt_ext = {1'b0, count_r};
  assign k_idx   = IDX_W'(in_req.position - POS_W'(1));
  assign ins_ok  = (in_req.position != '0) && (pos_ext <= cnt_ext + (COUNT_W+1)'(1)) &&
                   (cnt_ext < (COUNT_W+1)'(DEPTH));
  assign rd_ok   = (in_req.position != '0) && (pos_ext <= cnt_ext);

  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        found     = 1'b1;
        found_pos = POS_W'(i + 1);
      end
    end
  end

  always_comb begin
    op        = OP_HOLD;
    count_nxt = count_r;
    res_nxt   = '0;
    unique case (in_req.kind)
      KIND_INSERT: begin
        if (ins_ok) begin
          op         = OP_INSERT;
          count_nxt  = count_r + COUNT_W'(1);
          res_nxt.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (rd_ok) begin
          op                = OP_DELETE;
          count_nxt         = count_r - COUNT_W'(1);
          res_nxt.ok        = 1'b1;
          res_nxt.value_out = cell_data[k_idx];
        end
      end
      KIND_GET: begin
        if (rd_ok) begin
          res_nxt.ok        = 1'b1;
          res_nxt.value_out = cell_data[k_idx];
        end
      end
      KIND_LOCATE: begin
        res_nxt.ok             = found;
        res_nxt.found_position = found_pos;
      end
      KIND_CLEAR: begin
        count_nxt  = '0;
        res_nxt.ok = 1'b1;
      end
      default: res_nxt = '0;
    endcase
    res_nxt.count = count_nxt;
  end

  always_comb begin
    cmd.op    = accept ? op : OP_HOLD;
    cmd.k     = k_idx;
    cmd.value = in_req.value_in;
    cmd.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res_nxt;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_res    = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(DEPTH))
    else $error("fill count exceeds capacity");

  a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted request produced no result beat");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("fill count changed without a request");

  a_value_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.value_out != '0)) |-> out_res.ok)
    else $error("returned value on a failed request");

  a_found_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.found_position != '0)) |->
      (out_res.ok && (out_res.found_position <= out_res.count)))
    else $error("found position inconsistent with result");

endmodule
`default_nettype wire
